[rtl/pai_pkg.sv]
package pai_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int TIME_W     = 32;
    localparam int VAL_W      = 24;
    localparam int INTERP_W   = 2;
    localparam int ENTRY_W    = TIME_W + VAL_W + INTERP_W;
    localparam int DT_W       = 17;
    localparam logic [DT_W-1:0] DT_ONE     = 17'd65536;
    localparam logic [DT_W-1:0] STEP_LIMIT = 17'd65530;

    localparam logic [INTERP_W-1:0] INTERP_LINEAR = 2'd0;
    localparam logic [INTERP_W-1:0] INTERP_GAP    = 2'd1;
    localparam logic [INTERP_W-1:0] INTERP_STEP   = 2'd2;
    localparam logic [INTERP_W-1:0] INTERP_CUBIC  = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0]   ftime;
        logic [VAL_W-1:0]    fvalue;
        logic [INTERP_W-1:0] finterp;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_SHIFT,
        ST_INS_WR,
        ST_TK_RD,
        ST_TK_CHK,
        ST_TK_RD0,
        ST_TK_RD1,
        ST_TK_RD2,
        ST_TK_RD3,
        ST_TK_DIV,
        ST_TK_EVAL,
        ST_DROP_RD,
        ST_DROP_WR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [TIME_W-1:0]  num;
        logic [TIME_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DT_W-1:0]    quot;
    } div_rsp_t;

    function automatic logic signed [VAL_W-1:0] sat24(input logic signed [35:0] v);
        logic signed [VAL_W-1:0] r;
        r = v[VAL_W-1:0];
        if (v > 36'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -36'sd8388608) begin
            r = 24'sh800000;
        end
        return r;
    endfunction

endpackage

[rtl/pai_ram.sv]
module pai_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/pai_div.sv]
module pai_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  pai_pkg::div_req_t req,
    output pai_pkg::div_rsp_t rsp
);

    localparam int W = pai_pkg::TIME_W;

    logic [W:0]   rem_reg, rem_next;
    logic [W-1:0] den_reg, den_next;
    logic [W-1:0] num_reg, num_next;
    logic [pai_pkg::DT_W-1:0] q_reg, q_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [W+1:0] trial;
    logic [W:0]   shifted;

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[W-1:0], num_reg[W-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        if (req.start) begin
            rem_next  = '0;
            den_next  = req.den;
            num_next  = req.num;
            q_next    = '0;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[W-2:0], 1'b0};
            if (!trial[W+1]) begin
                rem_next = trial[W:0];
                q_next   = {q_reg[pai_pkg::DT_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                q_next   = {q_reg[pai_pkg::DT_W-2:0], 1'b0};
            end
            if ((q_next != '0 && q_reg[pai_pkg::DT_W-1]) || q_reg > pai_pkg::DT_ONE) begin
                q_next = pai_pkg::DT_ONE;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        q_reg   <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = (q_reg > pai_pkg::DT_ONE) ? pai_pkg::DT_ONE : q_reg;

endmodule

[rtl/pai_eval.sv]
module pai_eval (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [pai_pkg::INTERP_W-1:0]      interp,
    input  logic [pai_pkg::DT_W-1:0]          dt,
    input  logic signed [pai_pkg::VAL_W-1:0]  p0,
    input  logic signed [pai_pkg::VAL_W-1:0]  p1,
    input  logic signed [pai_pkg::VAL_W-1:0]  p2,
    input  logic signed [pai_pkg::VAL_W-1:0]  p3,
    output logic                              done,
    output logic signed [pai_pkg::VAL_W-1:0]  result
);

    logic signed [35:0] acc_reg, acc_next;
    logic signed [47:0] prod_reg, prod_next;
    logic signed [35:0] c2_reg, c1_reg, c0_reg;
    logic [2:0]         ph_reg, ph_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [pai_pkg::VAL_W-1:0] res_reg, res_next;
    logic signed [17:0] dts;
    logic signed [35:0] rnd;
    logic signed [35:0] lin;
    logic signed [35:0] fin;
    logic signed [35:0] e0, e1, e2, e3;

    assign dts = {1'b0, dt};
    assign e0  = 36'(p0);
    assign e1  = 36'(p1);
    assign e2  = 36'(p2);
    assign e3  = 36'(p3);
    assign rnd = 36'((prod_reg + 48'sd32768) >>> 16);
    assign fin = (acc_reg + 36'sd1) >>> 1;
    assign lin = e1 + rnd;

    always_comb begin
        acc_next  = acc_reg;
        prod_next = prod_reg;
        ph_next   = ph_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start) begin
            busy_next = 1'b1;
            ph_next   = 3'd0;
            if (interp == pai_pkg::INTERP_CUBIC) begin
                acc_next = -e0 + 36'sd3 * e1 - 36'sd3 * e2 + e3;
            end else begin
                acc_next = e2 - e1;
            end
        end else if (busy_reg) begin
            case (ph_reg)
                3'd0: begin
                    prod_next = 48'(acc_reg) * 48'(dts);
                    ph_next   = 3'd1;
                end
                3'd1: begin
                    if (interp == pai_pkg::INTERP_LINEAR) begin
                        res_next  = pai_pkg::sat24(lin);
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        acc_next = rnd + c2_reg;
                        ph_next  = 3'd2;
                    end
                end
                3'd2: begin
                    prod_next = 48'(acc_reg) * 48'(dts);
                    ph_next   = 3'd3;
                end
                3'd3: begin
                    acc_next = rnd + c1_reg;
                    ph_next  = 3'd4;
                end
                3'd4: begin
                    prod_next = 48'(acc_reg) * 48'(dts);
                    ph_next   = 3'd5;
                end
                3'd5: begin
                    acc_next = rnd + c0_reg;
                    ph_next  = 3'd6;
                end
                default: begin
                    res_next  = pai_pkg::sat24(fin);
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
            if (interp == pai_pkg::INTERP_GAP) begin
                res_next  = '0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (interp == pai_pkg::INTERP_STEP) begin
                res_next  = (dt < pai_pkg::STEP_LIMIT) ? p1 : p2;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ph_reg   <= ph_next;
        end
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        if (start) begin
            c2_reg <= 36'sd2 * e0 - 36'sd5 * e1 + 36'sd4 * e2 - e3;
            c1_reg <= e2 - e0;
            c0_reg <= 36'sd2 * e1;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[rtl/parameter_automation_interpolator_top.sv]
// Keyframe automation lane: a time-sorted table of up to 16 keyframes with
// linear, gap, step and Catmull-Rom cubic interpolation.
// Input channel (s_axis_*): one transaction is either an insert (tuser = 1)
// carrying key_time, key_value and key_interp, or a tick (tuser = 0)
// carrying sample_time. Every input transaction yields exactly one output
// transaction on m_axis_*.
// An insert walks the table with a read and a compare per entry and shifts
// the tail one entry per cycle. A tick walks the table, reads up to four
// neighbors, runs a restoring divide for dt (skipped for equal keyframe
// times) and a Horner evaluation on a single multiplier; a head drop moves
// every later entry down one slot. A tick without both neighbors returns
// after the walk and any head drop. One transaction is in flight at a time.
// Reset clears the keyframe count; table contents need no clearing.
// When the receiver stalls, the result holds in the output register and
// the block waits; no new input is taken until it is delivered.
module parameter_automation_interpolator_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] sample_time, [63:32] key_time, [87:64] key_value, [89:88] key_interp
    input  logic [95:0]  s_axis_tdata,
    // [0] mode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [23:0] out_value
    output logic [23:0]  m_axis_tdata,
    // [0] out_valid, [1] insert_ok
    output logic [1:0]   m_axis_tuser
);

    localparam int IW = pai_pkg::IDX_W;
    localparam int CW = pai_pkg::CNT_W;

    pai_pkg::state_t st_reg, st_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] k_reg, k_next;
    logic [31:0]   t_reg;
    pai_pkg::entry_t key_reg;
    pai_pkg::entry_t carry_reg, carry_next;
    pai_pkg::entry_t prev_reg, cur_reg;
    logic signed [23:0] p0_reg, p3_reg;
    logic          have_p0_reg, have_p3_reg;
    logic          valid_reg, valid_next;
    logic          ok_reg, ok_next;
    logic [23:0]   val_reg, val_next;
    logic          ovalid_reg, ovalid_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    pai_pkg::entry_t wdata, rdata;

    pai_pkg::div_req_t dreq;
    pai_pkg::div_rsp_t drsp;
    logic          ev_start, ev_done;
    logic          ev_start_reg;
    logic signed [23:0] ev_res;
    logic [pai_pkg::DT_W-1:0] dt_reg;

    pai_ram #(.WIDTH(pai_pkg::ENTRY_W), .DEPTH(pai_pkg::MAX_FRAMES)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    pai_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    pai_eval u_eval (
        .aclk(aclk), .aresetn(aresetn), .start(ev_start),
        .interp(cur_reg.finterp), .dt(dt_reg),
        .p0(have_p0_reg ? p0_reg : signed'(prev_reg.fvalue)),
        .p1(signed'(prev_reg.fvalue)),
        .p2(signed'(cur_reg.fvalue)),
        .p3(have_p3_reg ? p3_reg : signed'(cur_reg.fvalue)),
        .done(ev_done), .result(ev_res)
    );

    assign s_axis_tready = (st_reg == pai_pkg::ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = val_reg;
    assign m_axis_tuser  = {ok_reg, valid_reg};
    assign ev_start      = ev_start_reg;

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            pai_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser) begin
                        st_next = (cnt_reg >= CW'(pai_pkg::MAX_FRAMES)) ? pai_pkg::ST_OUT
                                  : pai_pkg::ST_INS_RD;
                    end else begin
                        st_next = pai_pkg::ST_TK_RD;
                    end
                end
            end
            pai_pkg::ST_INS_RD:  st_next = (pos_reg < cnt_reg) ? pai_pkg::ST_INS_CHK
                                            : pai_pkg::ST_INS_WR;
            pai_pkg::ST_INS_CHK: st_next = (rdata.ftime < key_reg.ftime) ? pai_pkg::ST_INS_RD
                                            : pai_pkg::ST_INS_SHIFT;
            pai_pkg::ST_INS_SHIFT: st_next = (k_reg + CW'(1) >= cnt_reg) ? pai_pkg::ST_INS_WR
                                              : pai_pkg::ST_INS_SHIFT;
            pai_pkg::ST_INS_WR:  st_next = pai_pkg::ST_OUT;
            pai_pkg::ST_TK_RD:   st_next = (pos_reg < cnt_reg) ? pai_pkg::ST_TK_CHK
                                            : pai_pkg::ST_TK_RD0;
            pai_pkg::ST_TK_CHK:  st_next = (rdata.ftime < t_reg) ? pai_pkg::ST_TK_RD
                                            : pai_pkg::ST_TK_RD0;
            pai_pkg::ST_TK_RD0: begin
                if (pos_reg >= CW'(1) && pos_reg < cnt_reg) begin
                    st_next = pai_pkg::ST_TK_RD1;
                end else begin
                    st_next = (pos_reg >= CW'(3)) ? pai_pkg::ST_DROP_RD : pai_pkg::ST_OUT;
                end
            end
            pai_pkg::ST_TK_RD1:  st_next = pai_pkg::ST_TK_RD2;
            pai_pkg::ST_TK_RD2:  st_next = pai_pkg::ST_TK_RD3;
            pai_pkg::ST_TK_RD3:  st_next = pai_pkg::ST_TK_DIV;
            pai_pkg::ST_TK_DIV:  st_next = (drsp.done || dt_reg == pai_pkg::DT_ONE)
                                            ? pai_pkg::ST_TK_EVAL : pai_pkg::ST_TK_DIV;
            pai_pkg::ST_TK_EVAL: begin
                if (ev_done) begin
                    st_next = (pos_reg >= CW'(3)) ? pai_pkg::ST_DROP_RD : pai_pkg::ST_OUT;
                end
            end
            pai_pkg::ST_DROP_RD: st_next = (k_reg + CW'(1) < cnt_reg) ? pai_pkg::ST_DROP_WR
                                            : pai_pkg::ST_OUT;
            pai_pkg::ST_DROP_WR: st_next = pai_pkg::ST_DROP_RD;
            pai_pkg::ST_OUT:     st_next = m_axis_tready ? pai_pkg::ST_IDLE : pai_pkg::ST_OUT;
            default:             st_next = pai_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        carry_next  = carry_reg;
        valid_next  = valid_reg;
        ok_next     = ok_reg;
        val_next    = val_reg;
        ovalid_next = ovalid_reg;
        we          = 1'b0;
        waddr       = k_reg[IW-1:0];
        wdata       = carry_reg;
        raddr       = pos_reg[IW-1:0];
        dreq.start  = 1'b0;
        dreq.num    = t_reg - prev_reg.ftime;
        dreq.den    = cur_reg.ftime - prev_reg.ftime;
        case (st_reg)
            pai_pkg::ST_IDLE: begin
                pos_next   = '0;
                valid_next = 1'b0;
                ok_next    = 1'b0;
                val_next   = '0;
            end
            pai_pkg::ST_INS_RD: begin
                raddr = pos_reg[IW-1:0];
            end
            pai_pkg::ST_INS_CHK: begin
                if (rdata.ftime < key_reg.ftime) begin
                    pos_next = pos_reg + CW'(1);
                end else begin
                    carry_next = rdata;
                    k_next     = pos_reg;
                end
                raddr = pos_reg[IW-1:0] + IW'(1);
            end
            pai_pkg::ST_INS_SHIFT: begin
                // carry holds entry k; rdata holds entry k+1
                we         = 1'b1;
                waddr      = IW'(k_reg + CW'(1));
                wdata      = carry_reg;
                carry_next = rdata;
                k_next     = k_reg + CW'(1);
                raddr      = IW'(k_reg + CW'(2));
            end
            pai_pkg::ST_INS_WR: begin
                we       = 1'b1;
                waddr    = pos_reg[IW-1:0];
                wdata    = key_reg;
                cnt_next = cnt_reg + CW'(1);
                ok_next  = 1'b1;
            end
            pai_pkg::ST_TK_CHK: begin
                if (rdata.ftime < t_reg) begin
                    pos_next = pos_reg + CW'(1);
                end
            end
            pai_pkg::ST_TK_RD0: begin
                raddr = IW'(pos_reg - CW'(1));
            end
            pai_pkg::ST_TK_RD1: begin
                raddr = pos_reg[IW-1:0];
            end
            pai_pkg::ST_TK_RD2: begin
                raddr = IW'(pos_reg - CW'(2));
            end
            pai_pkg::ST_TK_RD3: begin
                raddr = IW'(pos_reg + CW'(1));
            end
            pai_pkg::ST_TK_DIV: begin
                dreq.start = (prev_reg.ftime != cur_reg.ftime) && !drsp.done
                             && (dt_reg == '1);
            end
            pai_pkg::ST_TK_EVAL: begin
                if (ev_done) begin
                    valid_next = 1'b1;
                    val_next   = ev_res;
                    k_next     = '0;
                end
            end
            pai_pkg::ST_DROP_RD: begin
                raddr = IW'(k_reg + CW'(1));
                if (k_reg + CW'(1) >= cnt_reg) begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            pai_pkg::ST_DROP_WR: begin
                we     = 1'b1;
                waddr  = k_reg[IW-1:0];
                wdata  = rdata;
                k_next = k_reg + CW'(1);
            end
            pai_pkg::ST_OUT: begin
                ovalid_next = !m_axis_tready;
            end
            default: begin
            end
        endcase
        if (st_reg == pai_pkg::ST_TK_RD0 && st_next == pai_pkg::ST_DROP_RD) begin
            k_next = '0;
        end
        if (st_reg != pai_pkg::ST_OUT && st_next == pai_pkg::ST_OUT) begin
            ovalid_next = 1'b1;
        end
        if (st_reg == pai_pkg::ST_INS_RD && st_next == pai_pkg::ST_INS_WR) begin
            k_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= pai_pkg::ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            st_reg     <= st_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
        pos_reg   <= pos_next;
        k_reg     <= k_next;
        carry_reg <= carry_next;
        valid_reg <= valid_next;
        ok_reg    <= ok_next;
        val_reg   <= val_next;
        if (st_reg == pai_pkg::ST_IDLE) begin
            t_reg         <= s_axis_tdata[31:0];
            key_reg.ftime   <= s_axis_tdata[63:32];
            key_reg.fvalue  <= s_axis_tdata[87:64];
            key_reg.finterp <= s_axis_tdata[89:88];
        end
        if (st_reg == pai_pkg::ST_TK_RD1) begin
            prev_reg <= rdata;
        end
        if (st_reg == pai_pkg::ST_TK_RD2) begin
            cur_reg <= rdata;
        end
        if (st_reg == pai_pkg::ST_TK_RD3) begin
            p0_reg      <= signed'(rdata.fvalue);
            have_p0_reg <= (pos_reg >= CW'(2));
            dt_reg      <= '1;
        end
        if (st_reg == pai_pkg::ST_TK_DIV) begin
            if (dt_reg == '1) begin
                p3_reg      <= signed'(rdata.fvalue);
                have_p3_reg <= (pos_reg + CW'(1) < cnt_reg);
                if (prev_reg.ftime == cur_reg.ftime) begin
                    dt_reg <= pai_pkg::DT_ONE;
                end else begin
                    dt_reg <= {pai_pkg::DT_W{1'b1}} - 17'd1;
                end
            end else if (drsp.done) begin
                dt_reg <= drsp.quot;
            end
        end
        if (st_reg == pai_pkg::ST_TK_DIV && st_next == pai_pkg::ST_TK_EVAL) begin
            ev_start_reg <= 1'b1;
        end else begin
            ev_start_reg <= 1'b0;
        end
    end

endmodule
